>>> src/fwht_pkg.sv
// fwht_pkg: shared constants and types for the Walsh-Hadamard transform block
// no dependencies; imported by fast_walsh_hadamard_transform
package fwht_pkg;

  // field widths fixed by the interface
  localparam int LOG_BITS   = 3;
  localparam int INDEX_BITS = 6;
  localparam int VALUE_BITS = 20;

  // reset value of the transform length register
  localparam logic [LOG_BITS-1:0] LOG_RESET = 3'd6;

  // normalization coefficients in Q16
  localparam int FRAC_BITS = 16;
  localparam int COEF_BITS = 18;
  localparam logic signed [COEF_BITS-1:0] INV_SQRT2_Q16 = 18'sd46341;
  localparam logic signed [COEF_BITS-1:0] UNITY_Q16     = 18'sd65536;

  // tag carried alongside each result through the output pipeline
  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic                  last;
  } fwht_tag_t;

endpackage

>>> src/fast_walsh_hadamard_transform.sv
// fast_walsh_hadamard_transform: orthonormal Walsh-Hadamard transform, top level
// depends on fwht_pkg (constants, result tag type)
//
// Usage
//   cfg_wr_en/cfg_wr_data set log2 of the transform length N (reset 6; values
//   above the capacity of MAX_POINTS are clamped). A write restarts loading.
//   The input channel takes one sample per request, in index order. After the
//   N-th sample the block stalls its input, runs log2 N butterfly passes over
//   the vector store and then emits N scaled results in index order on the
//   output channel, out_last marking index N-1.
// Timing
//   Each butterfly pass issues one butterfly per cycle, limited by the two
//   store banks with one write port each, with an idle gap between passes.
//   After the last pass the sequencer enters S_BDONE; each result then passes
//   the store read register, the product register and the output register,
//   one result per cycle while out_stall is low.
// Reset and stall
//   rst_n (synchronous) clears control state and sets the length to 64; the
//   store needs no clearing. out_stall freezes the output pipeline and its
//   payload; the input is taken again once all results of a vector have reached the output register.
module fast_walsh_hadamard_transform #(
  parameter int MAX_POINTS  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [fwht_pkg::LOG_BITS-1:0]       cfg_wr_data,
  // sample requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  // result requests
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fwht_pkg::VALUE_BITS-1:0] out_value,
  output logic [fwht_pkg::INDEX_BITS-1:0]     out_index,
  output logic                                out_last
);
  import fwht_pkg::*;

  // sizes derived from the parameters
  localparam int LOG_MAX = $clog2(MAX_POINTS + 1) - 1;
  localparam int AW      = LOG_MAX;
  localparam int SW      = SAMPLE_BITS + LOG_MAX;
  localparam int BIW     = (LOG_MAX > 1) ? LOG_MAX - 1 : 1;
  localparam int BDEPTH  = 2 ** BIW;
  localparam int PW      = SW + COEF_BITS;
  localparam logic signed [PW-1:0] V_MAX = PW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] V_MIN = -V_MAX - PW'(1);

  typedef enum logic [1:0] {S_LOAD, S_BFLY, S_BDONE, S_OUT} state_t;

  // entries are split into two banks by address parity, so both halves of a
  // butterfly always sit in different banks
  function automatic logic [BIW-1:0] bank_idx(input logic [AW-1:0] a);
    return BIW'(a >> 1);
  endfunction

  state_t                state_r;
  logic [LOG_BITS-1:0]   log_points_r;
  logic [AW-1:0]         load_cnt_r;
  logic [LOG_BITS-1:0]   st_r;
  logic [AW-1:0]         bk_r;
  logic                  gap_r;
  logic                  wv_r;
  logic                  wpj_r;
  logic [AW-1:0]         wa_r;
  logic [AW-1:0]         wb_r;
  logic                  iss_act_r;
  logic [AW-1:0]         iss_cnt_r;
  logic                  v1_r;
  logic                  v2_r;
  logic                  sel1_r;
  fwht_tag_t             tag1_r;
  fwht_tag_t             tag2_r;
  logic signed [PW-1:0]  prod_r;
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [INDEX_BITS-1:0] out_index_r;
  logic                  out_last_r;

  // vector store, two banks
  logic [SW-1:0]         mem [2][BDEPTH];
  logic [SW-1:0]         rd_r [2];

  logic [LOG_BITS-1:0]   lg;
  logic [AW:0]           n_pts;
  logic [AW-1:0]         cnt_last;
  logic [AW-1:0]         bf_last;
  logic                  in_acc;
  logic                  adv;
  logic                  bf_iss;
  logic                  oiss;
  logic [AW-1:0]         h_w;
  logic [AW-1:0]         msk;
  logic [AW-1:0]         bj;
  logic [AW-1:0]         bjh;
  logic                  re;
  logic [BIW-1:0]        ra [2];
  logic                  we [2];
  logic [BIW-1:0]        wa [2];
  logic [SW-1:0]         wd [2];
  logic [SW-1:0]         bf_a;
  logic [SW-1:0]         bf_b;
  logic signed [SW-1:0]  x1;
  logic signed [COEF_BITS-1:0] coef;
  logic signed [PW-1:0]  prod_nxt;
  logic [1:0]            sh_s;
  logic signed [PW-1:0]  rnd;
  logic signed [PW-1:0]  shd;
  logic [VALUE_BITS-1:0] value_nxt;

  // effective length and counter limits
  always_comb begin
    lg       = (log_points_r > LOG_BITS'(LOG_MAX)) ? LOG_BITS'(LOG_MAX) : log_points_r;
    n_pts    = (AW + 1)'(1) << lg;
    cnt_last = AW'(n_pts - (AW + 1)'(1));
    bf_last  = AW'((n_pts >> 1) - (AW + 1)'(1));
  end

  // handshakes
  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign adv      = !out_valid_r || !out_stall;
  assign bf_iss   = (state_r == S_BFLY) && !gap_r;
  assign oiss     = (state_r == S_OUT) && iss_act_r && adv;

  // butterfly pair addresses: insert a zero at bit st of the butterfly count
  always_comb begin
    h_w = AW'(1) << st_r;
    msk = h_w - AW'(1);
    bj  = ((bk_r & ~msk) << 1) | (bk_r & msk);
    bjh = bj | h_w;
  end

  // store read ports
  always_comb begin
    re    = bf_iss || ((state_r == S_OUT) && adv);
    ra[0] = bank_idx(iss_cnt_r);
    ra[1] = bank_idx(iss_cnt_r);
    if (bf_iss) begin
      ra[^bj]  = bank_idx(bj);
      ra[^bjh] = bank_idx(bjh);
    end
  end

  // butterfly operands and store write ports
  always_comb begin
    bf_a  = rd_r[wpj_r];
    bf_b  = rd_r[!wpj_r];
    we[0] = 1'b0;
    we[1] = 1'b0;
    wa[0] = '0;
    wa[1] = '0;
    wd[0] = '0;
    wd[1] = '0;
    if (in_acc) begin
      we[^load_cnt_r] = 1'b1;
      wa[^load_cnt_r] = bank_idx(load_cnt_r);
      wd[^load_cnt_r] = SW'(in_sample);
    end
    if (wv_r) begin
      we[wpj_r]  = 1'b1;
      wa[wpj_r]  = bank_idx(wa_r);
      wd[wpj_r]  = bf_a + bf_b;
      we[!wpj_r] = 1'b1;
      wa[!wpj_r] = bank_idx(wb_r);
      wd[!wpj_r] = bf_a - bf_b;
    end
  end

  // store banks, one write and one registered read each
  always_ff @(posedge clk) begin
    for (int b = 0; b < 2; b++) begin
      if (we[b]) begin
        mem[b][wa[b]] <= wd[b];
      end
      if (re) begin
        rd_r[b] <= mem[b][ra[b]];
      end
    end
  end

  // scaling: multiply by 1 or 1/sqrt(2), then round and shift by 16 + L/2
  always_comb begin
    x1       = $signed(rd_r[sel1_r]);
    coef     = lg[0] ? INV_SQRT2_Q16 : UNITY_Q16;
    prod_nxt = x1 * coef;
    sh_s     = lg[LOG_BITS-1:1];
    rnd      = PW'(1) <<< (FRAC_BITS - 1 + int'(sh_s));
    shd      = (prod_r + rnd) >>> (FRAC_BITS + int'(sh_s));
    if (shd > V_MAX) begin
      value_nxt = V_MAX[VALUE_BITS-1:0];
    end else if (shd < V_MIN) begin
      value_nxt = V_MIN[VALUE_BITS-1:0];
    end else begin
      value_nxt = shd[VALUE_BITS-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (bf_iss) begin
      wpj_r <= ^bj;
      wa_r  <= bj;
      wb_r  <= bjh;
    end
    if (oiss) begin
      sel1_r       <= ^iss_cnt_r;
      tag1_r.index <= INDEX_BITS'(iss_cnt_r);
      tag1_r.last  <= (iss_cnt_r == cnt_last);
    end
    if (adv && v1_r) begin
      prod_r <= prod_nxt;
      tag2_r <= tag1_r;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      log_points_r <= LOG_RESET;
      load_cnt_r   <= '0;
      st_r         <= '0;
      bk_r         <= '0;
      gap_r        <= 1'b0;
      wv_r         <= 1'b0;
      iss_act_r    <= 1'b0;
      iss_cnt_r    <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // length register; a write drops a partly loaded vector
      if (cfg_wr_en) begin
        log_points_r <= cfg_wr_data;
        load_cnt_r   <= '0;
      end
      wv_r <= bf_iss;
      // output pipeline advances when the output register is empty or not stalled
      if (adv) begin
        v1_r        <= oiss;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
        if (v2_r) begin
          out_value_r <= value_nxt;
          out_index_r <= tag2_r.index;
          out_last_r  <= tag2_r.last;
        end
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (load_cnt_r == cnt_last) begin
              load_cnt_r <= '0;
              st_r       <= '0;
              bk_r       <= '0;
              gap_r      <= 1'b0;
              iss_cnt_r  <= '0;
              iss_act_r  <= (lg == '0);
              state_r    <= (lg == '0) ? S_OUT : S_BFLY;
            end else begin
              load_cnt_r <= load_cnt_r + AW'(1);
            end
          end
        end
        S_BFLY: begin
          // an idle gap between passes lets the last write of a pass land
          if (gap_r) begin
            gap_r <= 1'b0;
          end else if (bk_r == bf_last) begin
            bk_r <= '0;
            if (st_r == lg - LOG_BITS'(1)) begin
              state_r <= S_BDONE;
            end else begin
              st_r  <= st_r + LOG_BITS'(1);
              gap_r <= 1'b1;
            end
          end else begin
            bk_r <= bk_r + AW'(1);
          end
        end
        S_BDONE: begin
          iss_cnt_r <= '0;
          iss_act_r <= 1'b1;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (oiss) begin
            if (iss_cnt_r == cnt_last) begin
              iss_act_r <= 1'b0;
            end else begin
              iss_cnt_r <= iss_cnt_r + AW'(1);
            end
          end else if (!iss_act_r && !v1_r && !v2_r) begin
            state_r <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = $signed(out_value_r);
  assign out_index = out_index_r;
  assign out_last  = out_last_r;

endmodule
